[sv/rkl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkl_pkg
// Shared types and constants of the recent key list: request and result
// layouts, command codes, sequencer states and key store access.
// ----------------------------------------------------------------------------
package rkl_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CFG_W = 5;
  localparam int HALF_W = 64;
  localparam int KEY_W = 2 * HALF_W;
  localparam int POS_W = 4;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_DEL_KEY = 2'd1,
    CMD_DEL_POS = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [HALF_W-1:0] key_hi;
    logic [HALF_W-1:0] key_lo;
    logic [POS_W-1:0]  position;
  } in_req_t;

  typedef struct packed {
    logic               ok;
    logic               found;
    logic [COUNT_W-1:0] entry_count;
    logic [HALF_W-1:0]  read_hi;
    logic [HALF_W-1:0]  read_lo;
  } out_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH_RD,
    ST_SEARCH_CMP,
    ST_DN_RD,
    ST_DN_WR,
    ST_UP_RD,
    ST_UP_WR,
    ST_READ_RD,
    ST_READ_WT
  } state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             we;
    logic [CNT_W-1:0] cap;
  } cfg_wr_t;

  function automatic logic [CNT_W-1:0] sat_cap(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (int'(v) > DEPTH) begin
      r = CNT_W'(DEPTH);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

[sv/recent_key_list.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recent_key_list
// Move-to-front list of up to sixteen 128-bit keys, most recent at position 0.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the result has been formed. Every request produces exactly one result,
// shown on out_rsp for a single cycle with out_valid high; the receiver cannot
// stall it, so it must be captured in that cycle. All keys go through one
// 128-bit comparator and one key store with a registered read, so each
// entry compared takes a read step and a compare step, and each entry moved
// a read step and a write step. out_valid is high in the first cycle after
// the last busy cycle, or in the cycle after acceptance when busy never
// rises.
// cfg_ready is high only while the list is idle and start is low.
// ----------------------------------------------------------------------------
module recent_key_list (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  rkl_pkg::in_req_t          in_req,
  output logic                      out_valid,
  output rkl_pkg::out_rsp_t         out_rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rkl_pkg::CFG_W-1:0] cfg_max_entries
);

  logic [rkl_pkg::CNT_W-1:0] cap_r, cap_nxt;
  rkl_pkg::cfg_wr_t          cfg;
  rkl_pkg::mem_req_t         mem_req;
  logic [rkl_pkg::KEY_W-1:0] mem_rdata;

  // capacity saturates at the store depth
  always_comb begin
    cfg.we  = cfg_valid && cfg_ready;
    cfg.cap = rkl_pkg::sat_cap(cfg_max_entries);
    cap_nxt = cfg.we ? cfg.cap : cap_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  assign cfg_ready = !busy && !start;

  rkl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .cap       (cap_r),
    .cfg       (cfg),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  rkl_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (mem_rdata)
  );

endmodule

[sv/rkl_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkl_store
// Key slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rkl_store (
  input  logic                    clk,
  input  rkl_pkg::mem_req_t       mem_req,
  output logic [rkl_pkg::KEY_W-1:0] rdata
);

  logic [rkl_pkg::KEY_W-1:0] mem [rkl_pkg::DEPTH];
  logic [rkl_pkg::KEY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    rdata_r <= mem[mem_req.raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/rkl_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkl_ctrl
// Command sequencer: walks the key store through one shared 128-bit
// comparator, shifts entries one slot per step and issues the result.
// ----------------------------------------------------------------------------
module rkl_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  rkl_pkg::in_req_t          in_req,
  input  logic [rkl_pkg::CNT_W-1:0] cap,
  input  rkl_pkg::cfg_wr_t          cfg,
  output rkl_pkg::mem_req_t         mem_req,
  input  logic [rkl_pkg::KEY_W-1:0] mem_rdata,
  output logic                      out_valid,
  output rkl_pkg::out_rsp_t         out_rsp
);

  localparam int CW = rkl_pkg::CNT_W;
  localparam int IW = rkl_pkg::IDX_W;

  rkl_pkg::state_t          state_r, state_nxt;
  rkl_pkg::cmd_t            cmd_r, cmd_nxt;
  logic [rkl_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [CW-1:0]            len_r, len_nxt;
  logic [IW-1:0]            idx_r, idx_nxt;
  logic                     found_r, found_nxt;
  logic                     out_valid_r, out_valid_nxt;
  rkl_pkg::out_rsp_t        out_rsp_r, out_rsp_nxt;

  logic                     finish;
  logic                     ok_v;
  logic                     rd_v;
  logic                     key_hit;
  logic                     last_idx;
  logic [CW-1:0]            top;

  // the one shared comparator
  assign key_hit  = (mem_rdata == key_r);
  assign last_idx = ((CW'(idx_r) + CW'(1)) == len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rkl_pkg::ST_IDLE;
      len_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    idx_r     <= idx_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    finish        = 1'b0;
    ok_v          = 1'b0;
    rd_v          = 1'b0;
    top           = len_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx_r;
    mem_req.wdata = key_r;
    mem_req.raddr = idx_r;

    case (state_r)
      rkl_pkg::ST_IDLE: begin
        if (cfg.we && (len_r > cfg.cap)) begin
          len_nxt = cfg.cap;
        end
        if (start) begin
          cmd_nxt   = in_req.cmd;
          key_nxt   = {in_req.key_hi, in_req.key_lo};
          found_nxt = 1'b0;
          idx_nxt   = '0;
          if (cap == '0) begin
            finish = 1'b1;
          end else begin
            case (in_req.cmd)
              rkl_pkg::CMD_ADD: begin
                if (len_r == '0) begin
                  state_nxt = rkl_pkg::ST_DN_RD;
                end else begin
                  state_nxt = rkl_pkg::ST_SEARCH_RD;
                end
              end
              rkl_pkg::CMD_DEL_KEY: begin
                if (len_r == '0) begin
                  finish = 1'b1;
                end else begin
                  state_nxt = rkl_pkg::ST_SEARCH_RD;
                end
              end
              rkl_pkg::CMD_DEL_POS: begin
                if (int'(in_req.position) < int'(len_r)) begin
                  idx_nxt   = IW'(in_req.position);
                  state_nxt = rkl_pkg::ST_UP_RD;
                end else begin
                  finish = 1'b1;
                end
              end
              default: begin
                if (int'(in_req.position) < int'(len_r)) begin
                  idx_nxt   = IW'(in_req.position);
                  state_nxt = rkl_pkg::ST_READ_RD;
                end else begin
                  finish = 1'b1;
                end
              end
            endcase
          end
        end
      end
      rkl_pkg::ST_SEARCH_RD: begin
        state_nxt = rkl_pkg::ST_SEARCH_CMP;
      end
      rkl_pkg::ST_SEARCH_CMP: begin
        if (key_hit) begin
          found_nxt = 1'b1;
          if (cmd_r == rkl_pkg::CMD_ADD) begin
            state_nxt = rkl_pkg::ST_DN_RD;
          end else begin
            state_nxt = rkl_pkg::ST_UP_RD;
          end
        end else if (last_idx) begin
          if (cmd_r == rkl_pkg::CMD_ADD) begin
            // full list: oldest entry falls off
            if (len_r >= cap) begin
              top = cap - CW'(1);
            end
            len_nxt   = top;
            idx_nxt   = IW'(top);
            state_nxt = rkl_pkg::ST_DN_RD;
          end else begin
            ok_v   = 1'b1;
            finish = 1'b1;
          end
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = rkl_pkg::ST_SEARCH_RD;
        end
      end
      rkl_pkg::ST_DN_RD: begin
        if (idx_r == '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = '0;
          mem_req.wdata = key_r;
          if (!found_r) begin
            len_nxt = len_r + CW'(1);
          end
          ok_v   = 1'b1;
          finish = 1'b1;
        end else begin
          mem_req.raddr = idx_r - IW'(1);
          state_nxt     = rkl_pkg::ST_DN_WR;
        end
      end
      rkl_pkg::ST_DN_WR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = mem_rdata;
        idx_nxt       = idx_r - IW'(1);
        state_nxt     = rkl_pkg::ST_DN_RD;
      end
      rkl_pkg::ST_UP_RD: begin
        if (last_idx) begin
          len_nxt = len_r - CW'(1);
          ok_v    = 1'b1;
          finish  = 1'b1;
        end else begin
          mem_req.raddr = idx_r + IW'(1);
          state_nxt     = rkl_pkg::ST_UP_WR;
        end
      end
      rkl_pkg::ST_UP_WR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = mem_rdata;
        idx_nxt       = idx_r + IW'(1);
        state_nxt     = rkl_pkg::ST_UP_RD;
      end
      rkl_pkg::ST_READ_RD: begin
        state_nxt = rkl_pkg::ST_READ_WT;
      end
      rkl_pkg::ST_READ_WT: begin
        ok_v   = 1'b1;
        rd_v   = 1'b1;
        finish = 1'b1;
      end
      default: begin
        state_nxt = rkl_pkg::ST_IDLE;
      end
    endcase

    if (finish) begin
      state_nxt               = rkl_pkg::ST_IDLE;
      out_valid_nxt           = 1'b1;
      out_rsp_nxt.ok          = ok_v;
      out_rsp_nxt.found       = found_nxt;
      out_rsp_nxt.entry_count = rkl_pkg::COUNT_W'(len_nxt);
      out_rsp_nxt.read_hi     = rd_v ? mem_rdata[rkl_pkg::KEY_W-1:rkl_pkg::HALF_W] : '0;
      out_rsp_nxt.read_lo     = rd_v ? mem_rdata[rkl_pkg::HALF_W-1:0] : '0;
    end
  end

  assign busy      = (state_r != rkl_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  a_len_cap : assert property (@(posedge clk) disable iff (!rst_n) len_r <= cap)
    else $error("list length above capacity");

  a_rsp_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == rkl_pkg::ST_IDLE)
    else $error("result issued while sequencer active");

  a_wr_state : assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == rkl_pkg::ST_DN_RD || state_r == rkl_pkg::ST_DN_WR ||
                    state_r == rkl_pkg::ST_UP_WR))
    else $error("key store written outside a shift step");

  a_disabled : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && cap == '0) |=> (out_valid_r && !out_rsp_r.ok))
    else $error("disabled list must answer at once with ok low");

endmodule
